// ===== hdl/kvt_pkg.sv =====
// shared types and constants of the keyed vote tally
`timescale 1ns / 1ps
package kvt_pkg;

  localparam logic [1:0] OP_LOAD_CAND  = 2'd0;
  localparam logic [1:0] OP_LOAD_VOTER = 2'd1;
  localparam logic [1:0] OP_VOTE       = 2'd2;
  localparam logic [1:0] OP_FINISH     = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_DUP        = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_NO_VOTER   = 3'd3;
  localparam logic [2:0] ST_VOTED      = 3'd4;
  localparam logic [2:0] ST_NO_CAND    = 3'd5;
  localparam logic [2:0] ST_EMPTY      = 3'd6;

  localparam logic [31:0] GOLDEN_Q32   = 32'h9E37_79B9;
  localparam logic [10:0] VOTE_MAX     = 11'h7FF;

  typedef struct packed {
    logic       latch;
    logic       ksel;
    logic       hash1;
    logic       ld_c;
    logic       ld_v;
    logic       step_c;
    logic       step_v;
    logic       scan_init;
    logic       scan_upd;
    logic       wr_ins_c;
    logic       wr_ins_v;
    logic       wr_vote;
    logic       res_load;
    logic [2:0] res_st;
    logic       res_win;
    logic       clr_init;
    logic       clr_step;
  } dp_cmd_t;

  typedef struct packed {
    logic c_hit;
    logic c_empty;
    logic c_last;
    logic v_hit;
    logic v_empty;
    logic v_done;
    logic v_last;
    logic scan_last;
    logic any;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/kvt_ctrl.sv =====
// controller state machine of the keyed vote tally
`timescale 1ns / 1ps
module kvt_ctrl
  import kvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [1:0] in_cmd,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_H1   = 4'd1;
  localparam logic [3:0] S_H2   = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_SRD  = 4'd5;
  localparam logic [3:0] S_SCHK = 4'd6;
  localparam logic [3:0] S_RES  = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       ph_r, ph_nxt;
  logic [2:0] st_r, st_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      op_r    <= OP_LOAD_CAND;
      ph_r    <= 1'b0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      ph_r    <= ph_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ph_nxt    = ph_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.ksel  = ph_r;
    cmd.res_st = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          op_nxt    = in_cmd;
          ph_nxt    = 1'b0;
          if (in_cmd == OP_FINISH) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SRD;
          end else begin
            state_nxt = S_H1;
          end
        end
      end
      S_H1: begin
        cmd.hash1 = 1'b1;
        state_nxt = S_H2;
      end
      S_H2: begin
        if (op_r == OP_LOAD_CAND || ph_r) cmd.ld_c = 1'b1;
        else cmd.ld_v = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        state_nxt = S_RD;
        if (op_r == OP_LOAD_CAND) begin
          priority if (stat.c_hit) begin
            st_nxt = ST_DUP; state_nxt = S_RES;
          end else if (stat.c_empty) begin
            cmd.wr_ins_c = 1'b1; st_nxt = ST_OK; state_nxt = S_RES;
          end else if (stat.c_last) begin
            st_nxt = ST_FULL; state_nxt = S_RES;
          end else begin
            cmd.step_c = 1'b1;
          end
        end else if (op_r == OP_LOAD_VOTER) begin
          priority if (stat.v_hit) begin
            st_nxt = ST_DUP; state_nxt = S_RES;
          end else if (stat.v_empty) begin
            cmd.wr_ins_v = 1'b1; st_nxt = ST_OK; state_nxt = S_RES;
          end else if (stat.v_last) begin
            st_nxt = ST_FULL; state_nxt = S_RES;
          end else begin
            cmd.step_v = 1'b1;
          end
        end else if (!ph_r) begin
          priority if (stat.v_hit) begin
            if (stat.v_done) begin
              st_nxt = ST_VOTED; state_nxt = S_RES;
            end else begin
              ph_nxt = 1'b1; state_nxt = S_H1;
            end
          end else if (stat.v_empty || stat.v_last) begin
            st_nxt = ST_NO_VOTER; state_nxt = S_RES;
          end else begin
            cmd.step_v = 1'b1;
          end
        end else begin
          priority if (stat.c_hit) begin
            cmd.wr_vote = 1'b1; st_nxt = ST_OK; state_nxt = S_RES;
          end else if (stat.c_empty || stat.c_last) begin
            st_nxt = ST_NO_CAND; state_nxt = S_RES;
          end else begin
            cmd.step_c = 1'b1;
          end
        end
      end
      S_SRD: state_nxt = S_SCHK;
      S_SCHK: begin
        cmd.scan_upd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_RES;
        end else begin
          cmd.step_c = 1'b1;
          state_nxt  = S_SRD;
        end
      end
      S_RES: begin
        if (op_r == OP_FINISH) begin
          cmd.res_st  = stat.any ? ST_OK : ST_EMPTY;
          cmd.res_win = stat.any;
        end
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          if (op_r == OP_FINISH) begin
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/kvt_dp.sv =====
// datapath of the keyed vote tally: hash, probe pointers, tables, scan and result
`timescale 1ns / 1ps
module kvt_dp
  import kvt_pkg::*;
#(
  parameter int CAND_SLOTS  = 64,
  parameter int VOTER_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_key_m,
  input  logic [31:0] in_key_n,
  input  logic [31:0] in_cand_m,
  input  logic [31:0] in_cand_n,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_winner_m,
  output logic [31:0] out_winner_n,
  output logic [10:0] out_winner_votes,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  localparam int CAW  = $clog2(CAND_SLOTS);
  localparam int VAW  = $clog2(VOTER_SLOTS);
  localparam int MAXS = (CAND_SLOTS > VOTER_SLOTS) ? CAND_SLOTS : VOTER_SLOTS;
  localparam int PCW  = $clog2(MAXS);
  localparam logic [PCW:0] CS = (PCW + 1)'(CAND_SLOTS);
  localparam logic [PCW:0] VS = (PCW + 1)'(VOTER_SLOTS);

  // cand word: valid, votes, key; voter word: valid, done, key
  logic [75:0] cand_mem [CAND_SLOTS];
  logic [65:0] voter_mem [VOTER_SLOTS];
  logic [75:0] cand_rd_r;
  logic [65:0] voter_rd_r;

  logic [31:0]    km_r, kn_r, cm_r, cn_r;
  logic [31:0]    frac_r;
  logic [CAW-1:0] cptr_r;
  logic [VAW-1:0] vptr_r;
  logic [PCW-1:0] pc_r, clr_r;
  logic           any_r;
  logic [10:0]    best_votes_r;
  logic [63:0]    best_key_r;
  logic           out_valid_r;
  logic [2:0]     out_status_r;
  logic [31:0]    out_m_r, out_n_r;
  logic [10:0]    out_v_r;

  logic [31:0] hm, hn, hsum, hmag;
  logic [63:0] hprod, cprod, vprod;
  logic [63:0] ckey;
  logic [10:0] cvotes, cvotes_inc;
  logic        c_we, v_we;
  logic [CAW-1:0] c_wa;
  logic [VAW-1:0] v_wa;
  logic [75:0] c_wd;
  logic [65:0] v_wd;

  assign hm    = cmd.ksel ? cm_r : km_r;
  assign hn    = cmd.ksel ? cn_r : kn_r;
  assign hsum  = hm + hn;
  assign hmag  = hsum[31] ? (32'd0 - hsum) : hsum;
  assign hprod = {32'd0, hmag} * {32'd0, GOLDEN_Q32};
  assign cprod = {32'd0, frac_r} * 64'(CAND_SLOTS);
  assign vprod = {32'd0, frac_r} * 64'(VOTER_SLOTS);

  assign ckey       = cmd.ksel ? {cm_r, cn_r} : {km_r, kn_r};
  assign cvotes     = cand_rd_r[74:64];
  assign cvotes_inc = (cvotes == VOTE_MAX) ? cvotes : cvotes + 11'd1;

  always_comb begin
    stat.c_hit     = cand_rd_r[75] && (cand_rd_r[63:0] == ckey);
    stat.c_empty   = !cand_rd_r[75];
    stat.c_last    = (pc_r == PCW'(CAND_SLOTS - 1));
    stat.v_hit     = voter_rd_r[65] && (voter_rd_r[63:0] == {km_r, kn_r});
    stat.v_empty   = !voter_rd_r[65];
    stat.v_done    = voter_rd_r[64];
    stat.v_last    = (pc_r == PCW'(VOTER_SLOTS - 1));
    stat.scan_last = (cptr_r == CAW'(CAND_SLOTS - 1));
    stat.any       = any_r;
    stat.clr_last  = (clr_r == PCW'(MAXS - 1));
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    c_we = 1'b0;
    c_wa = cptr_r;
    c_wd = '0;
    v_we = 1'b0;
    v_wa = vptr_r;
    v_wd = '0;
    if (cmd.clr_step) begin
      c_we = ({1'b0, clr_r} < CS);
      c_wa = clr_r[CAW-1:0];
      v_we = ({1'b0, clr_r} < VS);
      v_wa = clr_r[VAW-1:0];
    end else begin
      if (cmd.wr_ins_c) begin
        c_we = 1'b1;
        c_wd = {1'b1, 11'd0, km_r, kn_r};
      end
      if (cmd.wr_ins_v) begin
        v_we = 1'b1;
        v_wd = {1'b1, 1'b0, km_r, kn_r};
      end
      if (cmd.wr_vote) begin
        c_we = 1'b1;
        c_wd = {1'b1, cvotes_inc, cm_r, cn_r};
        v_we = 1'b1;
        v_wd = {1'b1, 1'b1, km_r, kn_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) cand_mem[c_wa] <= c_wd;
    cand_rd_r <= cand_mem[cptr_r];
  end

  always_ff @(posedge clk) begin
    if (v_we) voter_mem[v_wa] <= v_wd;
    voter_rd_r <= voter_mem[vptr_r];
  end

  // transaction payload, hash and scan registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      km_r <= in_key_m;
      kn_r <= in_key_n;
      cm_r <= in_cand_m;
      cn_r <= in_cand_n;
    end
    if (cmd.hash1) frac_r <= hprod[31:0];
    if (cmd.scan_upd && cand_rd_r[75] && (!any_r || cvotes > best_votes_r)) begin
      best_votes_r <= cvotes;
      best_key_r   <= cand_rd_r[63:0];
    end
    if (cmd.res_load) begin
      out_status_r <= cmd.res_st;
      out_m_r      <= cmd.res_win ? best_key_r[63:32] : 32'd0;
      out_n_r      <= cmd.res_win ? best_key_r[31:0] : 32'd0;
      out_v_r      <= cmd.res_win ? best_votes_r : 11'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cptr_r      <= '0;
      vptr_r      <= '0;
      pc_r        <= '0;
      clr_r       <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld_c) begin
        cptr_r <= cprod[32 +: CAW];
        pc_r   <= '0;
      end else if (cmd.scan_init) begin
        cptr_r <= '0;
        pc_r   <= '0;
      end else if (cmd.step_c) begin
        cptr_r <= (cptr_r == CAW'(CAND_SLOTS - 1)) ? '0 : cptr_r + CAW'(1);
        pc_r   <= pc_r + PCW'(1);
      end
      if (cmd.ld_v) begin
        vptr_r <= vprod[32 +: VAW];
        pc_r   <= '0;
      end else if (cmd.step_v) begin
        vptr_r <= (vptr_r == VAW'(VOTER_SLOTS - 1)) ? '0 : vptr_r + VAW'(1);
        pc_r   <= pc_r + PCW'(1);
      end
      if (cmd.scan_init) any_r <= 1'b0;
      else if (cmd.scan_upd && cand_rd_r[75]) any_r <= 1'b1;
      if (cmd.clr_init) clr_r <= '0;
      else if (cmd.clr_step) clr_r <= stat.clr_last ? '0 : clr_r + PCW'(1);
      if (cmd.res_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_winner_m     = out_m_r;
  assign out_winner_n     = out_n_r;
  assign out_winner_votes = out_v_r;

endmodule

// ===== hdl/keyed_vote_tally_linear_probe.sv =====
// top level of the keyed vote tally with linear-probing hash tables
// A transaction hashes its key multiplicatively (S_H1 forms the product, S_H2 loads the
// probe pointer), then probes slot by slot, each probe a registered table read (S_RD) and
// a check (S_CHK); a vote probes the voter table, hashes the candidate key the same way
// and then probes the candidate table. S_RES loads the result register. Finish reads and
// checks all CAND_SLOTS entries, then, once the result is taken into the output register,
// clears both tables over max(CAND_SLOTS, VOTER_SLOTS) entries. The same clearing pass
// runs after reset; in_ready stays low throughout it. A result waits in the output register
// while the next transaction is accepted, up to the point where that one needs the register.
`timescale 1ns / 1ps
module keyed_vote_tally_linear_probe
  import kvt_pkg::*;
#(
  parameter int CAND_SLOTS  = 64,
  parameter int VOTER_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key_m,
  input  logic [31:0] in_key_n,
  input  logic [31:0] in_cand_m,
  input  logic [31:0] in_cand_n,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_winner_m,
  output logic [31:0] out_winner_n,
  output logic [10:0] out_winner_votes
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd)
  );

  kvt_dp #(
    .CAND_SLOTS  (CAND_SLOTS),
    .VOTER_SLOTS (VOTER_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_key_m         (in_key_m),
    .in_key_n         (in_key_n),
    .in_cand_m        (in_cand_m),
    .in_cand_n        (in_cand_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_winner_m     (out_winner_m),
    .out_winner_n     (out_winner_n),
    .out_winner_votes (out_winner_votes),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule
